FILE: src/pending_ack_tracker_macros.svh
// Assertion helpers shared by the tracker's RTL.
`ifndef PENDING_ACK_TRACKER_MACROS_SVH
`define PENDING_ACK_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pending_ack_tracker assertion failed");

// Next-cycle implication, disabled during reset.
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pending_ack_tracker assertion failed");

`endif

FILE: src/pat_pkg.sv
package pat_pkg;

   localparam logic [2:0] OP_BEGIN   = 3'd0;
   localparam logic [2:0] OP_FAIL    = 3'd1;
   localparam logic [2:0] OP_CONFIRM = 3'd2;
   localparam logic [2:0] OP_QUERY   = 3'd3;
   localparam logic [2:0] OP_POLL    = 3'd4;
   localparam logic [2:0] OP_CLEAR   = 3'd5;

   localparam logic [1:0] KIND_BOOL = 2'd0;
   localparam logic [1:0] KIND_U32  = 2'd1;
   localparam logic [1:0] KIND_F32  = 2'd2;

   localparam logic [1:0] STAT_IDLE    = 2'd0;
   localparam logic [1:0] STAT_PENDING = 2'd1;
   localparam logic [1:0] STAT_ERROR   = 2'd2;

   localparam int FL_PENDING  = 0;
   localparam int FL_ERROR    = 1;
   localparam int FL_HAS_BOOL = 2;
   localparam int FL_BOOL_VAL = 3;
   localparam int FL_HAS_U32  = 4;
   localparam int FL_HAS_F32  = 5;

   localparam logic CSR_TIMEOUT_SEL = 1'b0;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] device_id;
      logic [7:0]  endpoint;
      logic [63:0] key_tag;
      logic [1:0]  value_kind;
      logic        value_valid;
      logic [31:0] value;
      logic [63:0] now_ms;
   } pat_req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  status;
      logic        value_present;
      logic [31:0] stored_value;
   } pat_rsp_type;

   typedef struct packed {
      logic        used;
      logic [63:0] device;
      logic [7:0]  endpoint;
      logic [63:0] key;
      logic [5:0]  flags;
      logic [63:0] since;
      logic [31:0] word_value;
      logic [31:0] float_value;
   } pat_entry_type;

endpackage

FILE: src/pat_ram.sv
module pat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/pending_ack_tracker.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   pat_req_type
// rsp_      out        rsp_valid/rsp_stall   pat_rsp_type
// csr       in/out     psel/penable/pready   timeout limit at byte 0
//
// Begin, fail, confirm and query with a nonzero key scan the table one entry per cycle
// through the memory read port, then pass through the update and response states.
// A poll with a nonzero timeout rewrites every entry, a clear zeroes every entry, and other
// requests go straight to the response state. A request can be taken in the same cycle the
// response goes valid. After reset every entry is cleared before req_stall drops.
// A new request is taken while the last response is still stalled.
module pending_ack_tracker
   import pat_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pat_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pat_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "pending_ack_tracker_macros.svh"

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(pat_entry_type);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_POLL   = 3'd3;
   localparam logic [2:0] S_CLR    = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [31:0]   timeout_ff, timeout_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          hit_found_ff, hit_found_in;
   logic          free_found_ff, free_found_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   pat_entry_type hit_data_ff, hit_data_in;
   pat_req_type   req_ff, req_in;
   pat_rsp_type   res_ff, res_in;
   pat_rsp_type   rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   pat_entry_type mem_wdata, mem_rdata;
   logic [EW-1:0] mem_rbits;

   logic          csr_write;
   logic          cnt_live;
   logic          key_match;
   pat_entry_type cur, fresh, upd;
   logic          is_alloc, have;
   logic [63:0]   age;

   assign mem_rdata = pat_entry_type'(mem_rbits);

   pat_ram #(
      .WIDTH(EW),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rbits)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_TIMEOUT_SEL) ? timeout_ff : 32'd0;
   assign timeout_in = (csr_write && paddr[2] == CSR_TIMEOUT_SEL) ? pwdata : timeout_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt_live  = (cnt_ff < CW'(ENTRIES));
   assign mem_raddr = cnt_live ? cnt_ff[AW-1:0] : '0;

   assign key_match = mem_rdata.used && mem_rdata.endpoint == req_ff.endpoint &&
                      mem_rdata.device == req_ff.device_id && mem_rdata.key == req_ff.key_tag;

   assign is_alloc = (req_ff.req_type == OP_BEGIN) || (req_ff.req_type == OP_CONFIRM);
   assign have     = hit_found_ff || (is_alloc && free_found_ff);
   assign age      = req_ff.now_ms - mem_rdata.since;

   always_comb begin
      fresh          = '0;
      fresh.used     = 1'b1;
      fresh.device   = req_ff.device_id;
      fresh.endpoint = req_ff.endpoint;
      fresh.key      = req_ff.key_tag;
      cur            = hit_found_ff ? hit_data_ff : fresh;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = mem_raddr;
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      hit_data_in   = hit_data_ff;
      clr_rsp_in    = clr_rsp_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_idx_ff;
      mem_wdata     = mem_rdata;
      upd           = cur;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_in        = '0;
               cnt_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               clr_rsp_in    = 1'b1;
               if (req_data.req_type <= OP_QUERY && req_data.key_tag != 64'd0) begin
                  state_in = S_SCAN;
               end else if (req_data.req_type == OP_POLL && timeout_ff != 32'd0) begin
                  state_in = S_POLL;
               end else if (req_data.req_type == OP_CLEAR) begin
                  state_in = S_CLR;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            rd_vld_in = cnt_live;
            if (cnt_live) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (key_match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_data_in  = mem_rdata;
               end
               if (!mem_rdata.used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
            end else if (!cnt_live) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            mem_waddr = hit_found_ff ? hit_idx_ff : free_idx_ff;
            case (req_ff.req_type)
               OP_BEGIN: begin
                  if (have && !cur.flags[FL_PENDING]) begin
                     upd.flags[FL_PENDING] = 1'b1;
                     upd.flags[FL_ERROR]   = 1'b0;
                     upd.since             = '0;
                     mem_we                = 1'b1;
                     res_in.accepted       = 1'b1;
                  end
               end
               OP_FAIL: begin
                  if (hit_found_ff) begin
                     upd.flags[FL_PENDING] = 1'b0;
                     upd.flags[FL_ERROR]   = 1'b1;
                     mem_we                = 1'b1;
                  end
               end
               OP_CONFIRM: begin
                  if (have) begin
                     upd.flags[FL_PENDING] = 1'b0;
                     upd.flags[FL_ERROR]   = 1'b0;
                     upd.since             = '0;
                     mem_we                = 1'b1;
                     case (req_ff.value_kind)
                        KIND_BOOL: begin
                           upd.flags[FL_HAS_BOOL] = req_ff.value_valid;
                           upd.flags[FL_BOOL_VAL] = req_ff.value[0];
                        end
                        KIND_U32: begin
                           upd.flags[FL_HAS_U32] = req_ff.value_valid;
                           upd.word_value        = req_ff.value;
                        end
                        KIND_F32: begin
                           upd.flags[FL_HAS_F32] = req_ff.value_valid;
                           upd.float_value       = req_ff.value;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               OP_QUERY: begin
                  if (hit_found_ff) begin
                     res_in.accepted = 1'b1;
                     if (cur.flags[FL_PENDING]) begin
                        res_in.status = STAT_PENDING;
                     end else if (cur.flags[FL_ERROR]) begin
                        res_in.status = STAT_ERROR;
                     end else begin
                        res_in.status = STAT_IDLE;
                     end
                     case (req_ff.value_kind)
                        KIND_BOOL: begin
                           res_in.value_present = cur.flags[FL_HAS_BOOL];
                           res_in.stored_value  = {31'd0, cur.flags[FL_BOOL_VAL]};
                        end
                        KIND_U32: begin
                           res_in.value_present = cur.flags[FL_HAS_U32];
                           res_in.stored_value  = cur.word_value;
                        end
                        KIND_F32: begin
                           res_in.value_present = cur.flags[FL_HAS_F32];
                           res_in.stored_value  = cur.float_value;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
            mem_wdata = upd;
            state_in  = S_RESP;
         end
         S_POLL: begin
            rd_vld_in = cnt_live;
            if (cnt_live) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               // Each entry is read once and written back the next cycle.
               mem_we = 1'b1;
               if (mem_rdata.used && mem_rdata.flags[FL_PENDING]) begin
                  if (mem_rdata.since == 64'd0) begin
                     mem_wdata.since = req_ff.now_ms;
                  end else if (req_ff.now_ms > mem_rdata.since &&
                               age >= {32'd0, timeout_ff}) begin
                     mem_wdata.flags[FL_PENDING] = 1'b0;
                     mem_wdata.flags[FL_ERROR]   = 1'b1;
                  end
               end
            end else if (!cnt_live) begin
               state_in = S_RESP;
            end
         end
         S_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = '0;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         timeout_ff   <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      hit_found_ff  <= hit_found_in;
      free_found_ff <= free_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      hit_data_ff   <= hit_data_in;
      req_ff        <= req_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `PAT_ASSERT_NOW(a_we_states, clock, reset, mem_we,
      state_ff == S_UPDATE || state_ff == S_POLL || state_ff == S_CLR)
   `PAT_ASSERT_NOW(a_poll_wb_addr, clock, reset, state_ff == S_POLL && mem_we,
      mem_waddr == $past(mem_raddr))
   `PAT_ASSERT_NOW(a_scan_start_clean, clock, reset, state_ff == S_SCAN && cnt_ff == '0,
      !hit_found_ff && !free_found_ff)
   `PAT_ASSERT_NOW(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_RESP)

endmodule

FILE: tb/pending_ack_tracker_test.sv
module pending_ack_tracker_test;
   import pat_pkg::*;

   localparam int SLOTS = 128;
   localparam int SCAN_CYCLES = SLOTS + 20;
   localparam int STUCK_LIMIT = 4000;

   class ack_table_model;
      logic [31:0] limit_ms;
      bit          used [SLOTS];
      logic [63:0] dev [SLOTS];
      logic [7:0]  ep [SLOTS];
      logic [63:0] key [SLOTS];
      logic [5:0]  flags [SLOTS];
      logic [63:0] since [SLOTS];
      logic [31:0] word_val [SLOTS];
      logic [31:0] float_val [SLOTS];
      pat_rsp_type expected_rsp [$];
      int          mismatches;

      function new();
         limit_ms = 0;
         mismatches = 0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < SLOTS; i++) begin
            used[i] = 0;
            flags[i] = '0;
            since[i] = '0;
            word_val[i] = '0;
            float_val[i] = '0;
         end
      endfunction

      function int find(logic [63:0] d, logic [7:0] e, logic [63:0] k);
         for (int i = 0; i < SLOTS; i++)
            if (used[i] && ep[i] == e && dev[i] == d && key[i] == k) return i;
         return -1;
      endfunction

      function int find_or_take(logic [63:0] d, logic [7:0] e, logic [63:0] k);
         int i;
         i = find(d, e, k);
         if (i >= 0) return i;
         for (i = 0; i < SLOTS; i++) begin
            if (!used[i]) begin
               used[i] = 1;
               dev[i] = d;
               ep[i] = e;
               key[i] = k;
               flags[i] = '0;
               since[i] = '0;
               word_val[i] = '0;
               float_val[i] = '0;
               return i;
            end
         end
         return -1;
      endfunction

      function void note_request(pat_req_type r);
         pat_rsp_type o;
         int i;
         logic [5:0] f;
         o = '0;
         if (r.req_type <= OP_QUERY && r.key_tag != 0) begin
            case (r.req_type)
               OP_BEGIN: begin
                  i = find_or_take(r.device_id, r.endpoint, r.key_tag);
                  if (i >= 0 && !flags[i][FL_PENDING]) begin
                     flags[i][FL_PENDING] = 1;
                     flags[i][FL_ERROR] = 0;
                     since[i] = '0;
                     o.accepted = 1;
                  end
               end
               OP_FAIL: begin
                  i = find(r.device_id, r.endpoint, r.key_tag);
                  if (i >= 0) begin
                     flags[i][FL_PENDING] = 0;
                     flags[i][FL_ERROR] = 1;
                  end
               end
               OP_CONFIRM: begin
                  i = find_or_take(r.device_id, r.endpoint, r.key_tag);
                  if (i >= 0) begin
                     f = flags[i];
                     f[FL_PENDING] = 0;
                     f[FL_ERROR] = 0;
                     since[i] = '0;
                     if (r.value_kind == KIND_BOOL) begin
                        f[FL_HAS_BOOL] = r.value_valid;
                        f[FL_BOOL_VAL] = r.value[0];
                     end else if (r.value_kind == KIND_U32) begin
                        f[FL_HAS_U32] = r.value_valid;
                        word_val[i] = r.value;
                     end else if (r.value_kind == KIND_F32) begin
                        f[FL_HAS_F32] = r.value_valid;
                        float_val[i] = r.value;
                     end
                     flags[i] = f;
                  end
               end
               default: begin
                  i = find(r.device_id, r.endpoint, r.key_tag);
                  if (i >= 0) begin
                     f = flags[i];
                     o.accepted = 1;
                     o.status = f[FL_PENDING] ? STAT_PENDING :
                                (f[FL_ERROR] ? STAT_ERROR : STAT_IDLE);
                     if (r.value_kind == KIND_BOOL) begin
                        o.value_present = f[FL_HAS_BOOL];
                        o.stored_value = {31'd0, f[FL_BOOL_VAL]};
                     end else if (r.value_kind == KIND_U32) begin
                        o.value_present = f[FL_HAS_U32];
                        o.stored_value = word_val[i];
                     end else if (r.value_kind == KIND_F32) begin
                        o.value_present = f[FL_HAS_F32];
                        o.stored_value = float_val[i];
                     end
                  end
               end
            endcase
         end else if (r.req_type == OP_POLL) begin
            if (limit_ms != 0) begin
               for (i = 0; i < SLOTS; i++) begin
                  if (used[i] && flags[i][FL_PENDING]) begin
                     if (since[i] == 0) begin
                        since[i] = r.now_ms;
                     end else if (r.now_ms > since[i] &&
                                  (r.now_ms - since[i]) >= {32'd0, limit_ms}) begin
                        flags[i][FL_PENDING] = 0;
                        flags[i][FL_ERROR] = 1;
                     end
                  end
               end
            end
         end else if (r.req_type == OP_CLEAR) begin
            wipe();
         end
         expected_rsp.push_back(o);
      endfunction

      function void check_response(pat_rsp_type got);
         pat_rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("response with no transaction outstanding: %h", got);
            mismatches++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.value_present !== want.value_present) begin
            $error("value_present: expected %0d, actual %0d",
                   want.value_present, got.value_present);
            mismatches++;
         end
         if (got.stored_value !== want.stored_value) begin
            $error("stored_value: expected %h, actual %h", want.stored_value, got.stored_value);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pat_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   pat_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ack_table_model table_model;
   bit          no_idle;
   int          stuck_cycles;
   logic [63:0] clock_ms;
   logic [63:0] dev_pool [3];
   logic [63:0] key_pool [5];
   logic [7:0]  ep_pool [3];

   pending_ack_tracker u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) table_model.note_request(req_data);
         if (rsp_valid && !rsp_stall) table_model.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receiver side: random back-pressure before each response.
   initial begin
      int n;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         @(posedge clock iff (rsp_valid && !rsp_stall));
      end
   end

   // Valid stays high after the accepting edge; the next send or drain decides.
   task automatic send(pat_req_type r);
      int n;
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock iff (req_valid && !req_stall));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (table_model.expected_rsp.size() != 0) @(posedge clock);
      repeat (SCAN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= 3'd0;
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock iff pready);
      table_model.limit_ms = v;
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   function automatic pat_req_type build(logic [2:0] op, logic [63:0] d, logic [7:0] e,
                                         logic [63:0] k, logic [1:0] kind, logic has,
                                         logic [31:0] v, logic [63:0] now);
      pat_req_type r;
      r.req_type = op;
      r.device_id = d;
      r.endpoint = e;
      r.key_tag = k;
      r.value_kind = kind;
      r.value_valid = has;
      r.value = v;
      r.now_ms = now;
      return r;
   endfunction

   function automatic pat_req_type random_request();
      pat_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) r.req_type = OP_BEGIN;
      else if (pick < 32) r.req_type = OP_FAIL;
      else if (pick < 50) r.req_type = OP_CONFIRM;
      else if (pick < 78) r.req_type = OP_QUERY;
      else if (pick < 95) r.req_type = OP_POLL;
      else if (pick < 97) r.req_type = OP_CLEAR;
      else r.req_type = 3'($urandom_range(6, 7));
      r.device_id = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                                  : dev_pool[$urandom_range(0, 2)];
      r.endpoint = ($urandom_range(0, 15) == 0) ? 8'($urandom) : ep_pool[$urandom_range(0, 2)];
      pick = $urandom_range(0, 19);
      if (pick == 0) r.key_tag = '0;
      else if (pick == 1) r.key_tag = {$urandom, $urandom};
      else r.key_tag = key_pool[$urandom_range(0, 4)];
      r.value_kind = 2'($urandom_range(0, 3));
      r.value_valid = 1'($urandom);
      r.value = $urandom;
      clock_ms += 64'($urandom_range(0, 60));
      pick = $urandom_range(0, 29);
      if (pick == 0) r.now_ms = {$urandom, $urandom};
      else if (pick == 1) r.now_ms = '0;
      else r.now_ms = clock_ms;
      return r;
   endfunction

   initial begin
      logic [31:0] settings [5];
      table_model = new();
      no_idle = 0;
      stuck_cycles = 0;
      clock_ms = 64'd1000;
      dev_pool = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0};
      key_pool = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd77,
                   64'h00C0_FFEE_0000_0042};
      ep_pool = '{8'd0, 8'd255, 8'd17};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed: extremes, each request kind, and the corner cases.
      send(build(OP_QUERY, '1, 8'd255, '1, KIND_U32, 0, 0, 0));
      send(build(OP_BEGIN, '1, 8'd255, '0, KIND_BOOL, 1, 1, 0));
      send(build(OP_QUERY, '1, 8'd255, '0, KIND_BOOL, 0, 0, 0));
      send(build(OP_BEGIN, '1, 8'd255, '1, KIND_BOOL, 0, 0, 0));
      send(build(OP_BEGIN, '1, 8'd255, '1, KIND_BOOL, 0, 0, 0));
      send(build(OP_POLL, 0, 0, 0, 0, 0, 0, 64'd500));
      send(build(OP_QUERY, '1, 8'd255, '1, KIND_BOOL, 0, 0, 0));
      send(build(OP_FAIL, '1, 8'd255, '1, KIND_BOOL, 0, 0, 0));
      send(build(OP_QUERY, '1, 8'd255, '1, KIND_F32, 0, 0, 0));
      send(build(OP_CONFIRM, '1, 8'd255, '1, KIND_BOOL, 1, 32'hFFFF_FFFF, 0));
      send(build(OP_CONFIRM, '1, 8'd255, '1, KIND_U32, 1, 32'hFFFF_FFFF, 0));
      send(build(OP_CONFIRM, 0, 0, 64'd1, KIND_F32, 1, 32'h3F80_0000, 0));
      send(build(OP_CONFIRM, 0, 0, 64'd1, 2'd3, 1, 32'h5555_AAAA, 0));
      send(build(OP_QUERY, '1, 8'd255, '1, KIND_BOOL, 0, 0, 0));
      send(build(OP_QUERY, '1, 8'd255, '1, KIND_U32, 0, 0, 0));
      send(build(OP_QUERY, 0, 0, 64'd1, KIND_F32, 0, 0, 0));
      send(build(OP_QUERY, 0, 0, 64'd1, 2'd3, 0, 0, 0));
      send(build(OP_FAIL, 0, 0, 64'd99, KIND_BOOL, 0, 0, 0));
      send(build(3'd6, '1, 8'd255, '1, 2'd3, 1, '1, '1));
      send(build(3'd7, '1, 8'd255, '1, 2'd3, 1, '1, '1));
      send(build(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      send(build(OP_QUERY, 0, 0, 64'd1, KIND_F32, 0, 0, 0));

      // Fill the table, then a begin and a confirm with no room left.
      no_idle = 1;
      for (int i = 1; i <= SLOTS; i++)
         send(build(OP_BEGIN, 64'd5, 8'd3, 64'(i), KIND_BOOL, 0, 0, 0));
      send(build(OP_BEGIN, 64'd5, 8'd3, 64'd999, KIND_BOOL, 0, 0, 0));
      send(build(OP_CONFIRM, 64'd5, 8'd3, 64'd999, KIND_U32, 1, 32'd7, 0));
      send(build(OP_QUERY, 64'd5, 8'd3, 64'd999, KIND_U32, 0, 0, 0));
      send(build(OP_QUERY, 64'd5, 8'd3, 64'd128, KIND_U32, 0, 0, 0));
      send(build(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      no_idle = 0;

      // Each setting waits for an idle block before the register write.
      settings = '{32'd1, 32'hFFFF_FFFF, 32'd50, $urandom_range(1, 400), 32'd0};
      for (int p = 0; p < 5; p++) begin
         drain();
         write_timeout(settings[p]);
         no_idle = (p == 2);
         for (int n = 0; n < 240; n++) send(random_request());
      end

      drain();
      if (table_model.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
